// ===== rtl/core/phc_pkg.sv =====
`timescale 1ns / 1ps

package phc_pkg;

    // Fixed point layout
    localparam int TEMP_FRAC_BITS   = 8;
    localparam int SCALE_BITS       = 20 + TEMP_FRAC_BITS;   // controller output, 2^-SCALE_BITS %
    localparam int GAIN_ALIGN_SHIFT = 8;                     // integrator and P/D terms in 1/256

    // Field widths
    localparam int FUNC_W     = 3;
    localparam int MODE_W     = 3;
    localparam int SP_W       = 6;
    localparam int TEMP_W     = 17;
    localparam int ERRF_W     = 20;
    localparam int ERR_W      = 18;
    localparam int DERR_W     = 19;
    localparam int INTEG_W    = 16;
    localparam int INTEG_SUM_W = 26;
    localparam int INC_W      = 25;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 14;
    localparam int PCT_W      = 7;
    localparam int STEP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Shared multiplier and datapath widths
    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 46;
    localparam int MAG_W  = SCALE_BITS + PCT_W;
    localparam int SUM_W  = MAG_W + DUTY_W;
    localparam int V_W    = PCT_W + DUTY_W;
    localparam int DSR_W  = DUTY_W + PCT_W - 1;

    // Error saturation and integrator clamp
    localparam int ERR_MAXV    = 2 ** (ERR_W - 1) - 1;
    localparam int ERR_MINV    = -(2 ** (ERR_W - 1));
    localparam int INTEG_LIMIT = 25600;
    localparam int INC_BIAS    = 5 * (2 ** TEMP_FRAC_BITS);

    // Floor divide by ten: offset to positive, multiply by reciprocal
    localparam int DIV10_SHIFT = 27;
    localparam int DIV10_K     = 13421773;
    localparam int DIV10_Q_W   = 24;
    localparam int DIV10_OFS_Q = 2 ** 22;
    localparam int DIV10_OFS   = 10 * DIV10_OFS_Q;

    // Divide by one hundred by reciprocal
    localparam int DIV100_SHIFT = 28;
    localparam int DIV100_K     = 2684355;

    // Percent scale
    localparam int     PCT_FULL     = 100;
    localparam int     DEADBAND_PCT = 2;
    localparam longint PCT_UNIT     = 64'sd1 <<< SCALE_BITS;

    // Setpoint range and manual levels
    localparam logic [SP_W-1:0]   SP_MIN   = 6'd10;
    localparam logic [SP_W-1:0]   SP_MAX   = 6'd50;
    localparam logic [SP_W-1:0]   SP_RESET = 6'd25;
    localparam logic [DUTY_W-1:0] HEAT_L1  = 14'd3000;
    localparam logic [DUTY_W-1:0] HEAT_L2  = 14'd5500;
    localparam logic [PCT_W-1:0]  FAN_T1   = 7'd33;
    localparam logic [PCT_W-1:0]  FAN_T2   = 7'd66;
    localparam logic [PCT_W-1:0]  FAN_T3   = 7'd100;

    // Event codes
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MENU   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_UP     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DOWN   = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN1_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN2_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH  = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]        KP_RESET    = 16'd20480;
    localparam logic [GAIN_W-1:0]        KI_RESET    = 16'd4096;
    localparam logic [GAIN_W-1:0]        KD_RESET    = 16'd41;
    localparam logic [DUTY_W-1:0]        FAN1_RESET  = 14'd2500;
    localparam logic [DUTY_W-1:0]        FAN2_RESET  = 14'd5200;
    localparam logic [DUTY_W-1:0]        FULL_RESET  = 14'd8399;
    localparam logic signed [TEMP_W-1:0] TLOW_RESET  = -17'sd1280;
    localparam logic signed [TEMP_W-1:0] THIGH_RESET = 17'sd21760;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE = 3'd0,
        MODE_SET  = 3'd1,
        MODE_PID  = 3'd2,
        MODE_MAN  = 3'd3,
        MODE_ERR  = 3'd4
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SP_W-1:0]   setpoint_deg;
        logic [DUTY_W-1:0] first_fan_duty;
        logic [DUTY_W-1:0] second_fan_duty;
        logic [DUTY_W-1:0] heater_duty;
        logic [PCT_W-1:0]  fan_percent;
        logic [PCT_W-1:0]  heater_percent;
        logic [STEP_W-1:0] manual_fan_step;
        logic [STEP_W-1:0] manual_heat_step;
    } t_result;

    // Manual fan level to percent
    function automatic logic [PCT_W-1:0] fan_target(input logic [STEP_W-1:0] step);
        case (step)
            2'd1:    return FAN_T1;
            2'd2:    return FAN_T2;
            2'd3:    return FAN_T3;
            default: return '0;
        endcase
    endfunction

endpackage

// ===== rtl/core/phc_if.sv =====
`timescale 1ns / 1ps

// Event channel
interface phc_in_if import phc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, func, temperature, input ready);
    modport sink   (input valid, func, temperature, output ready);
endinterface

// Status channel
interface phc_out_if import phc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SP_W-1:0]   setpoint_deg;
    logic [DUTY_W-1:0] first_fan_duty;
    logic [DUTY_W-1:0] second_fan_duty;
    logic [DUTY_W-1:0] heater_duty;
    logic [PCT_W-1:0]  fan_percent;
    logic [PCT_W-1:0]  heater_percent;
    logic [STEP_W-1:0] manual_fan_step;
    logic [STEP_W-1:0] manual_heat_step;

    modport source (output valid, mode, setpoint_deg, first_fan_duty, second_fan_duty,
                    heater_duty, fan_percent, heater_percent, manual_fan_step,
                    manual_heat_step, input ready);
    modport sink   (input valid, mode, setpoint_deg, first_fan_duty, second_fan_duty,
                    heater_duty, fan_percent, heater_percent, manual_fan_step,
                    manual_heat_step, output ready);
endinterface

// ===== rtl/core/phc_mul.sv =====
`timescale 1ns / 1ps

// Shared signed multiplier, product registered
module phc_mul import phc_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/pid_heat_cool_mode_controller.sv =====
`timescale 1ns / 1ps
// One event in flight at a time; an event is accepted only in idle, and a new event can be taken
// in the same cycle that the status transaction of the last one is offered. The cost is set by the
// single shared multiplier (states S_CHI, S_CLO, S_CSUM, S_CDIV and S_CFIN per fan or heater channel)
// and the bit-per-cycle heater percent divider. Synchronous active-low reset restores defaults.
module pid_heat_cool_mode_controller import phc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    phc_in_if.sink                i_cmd,
    phc_out_if.source             o_res
);

    localparam logic signed [ACC_W-1:0] DB_LIM   = ACC_W'(DEADBAND_PCT * PCT_UNIT);
    localparam logic signed [ACC_W-1:0] FULL_MAG = ACC_W'(PCT_FULL * PCT_UNIT);
    localparam logic [1:0] CH_FAN1 = 2'd0;
    localparam logic [1:0] CH_FAN2 = 2'd1;
    localparam logic [1:0] CH_HEAT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_INC, S_INTEG, S_PTERM, S_ITERM, S_DTERM, S_SPLIT,
        S_CHI, S_CLO, S_CSUM, S_CDIV, S_CFIN, S_HDIV, S_DONE
    } t_state;

    // Configuration registers
    logic [GAIN_W-1:0]        r_kp, r_ki, r_kd;
    logic [DUTY_W-1:0]        r_min1, r_min2, r_full;
    logic signed [TEMP_W-1:0] r_tlow, r_thigh;

    // Controller state
    t_state                    r_state;
    t_mode                     r_mode;
    logic [SP_W-1:0]           r_setpoint;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last;
    logic [STEP_W-1:0]         r_fan_step, r_heat_step;
    logic [DUTY_W-1:0]         r_duty [3];
    logic [PCT_W-1:0]          r_power [2];
    logic                      r_out_valid;
    t_result                   r_res;

    // Working registers
    logic [FUNC_W-1:0]        r_func;
    logic signed [TEMP_W-1:0] r_temp;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ACC_W-1:0]  r_acc;
    logic [MAG_W-1:0]         r_mag;
    logic [MAG_W-1:0]         r_part;
    logic [V_W-1:0]           r_v;
    logic [1:0]               r_chan;
    logic [V_W-1:0]           r_rem;
    logic [DSR_W-1:0]         r_dsr;
    logic [PCT_W-1:0]         r_q;
    logic [2:0]               r_cnt;

    // Combinational helpers
    logic [ERRF_W-1:0]              sp_scaled;
    logic signed [ERRF_W-1:0]       err_full;
    logic signed [ERR_W-1:0]        err_sat;
    logic signed [MUL_W-1:0]        inc_x, inc_y, inc_u;
    logic signed [INC_W-1:0]        inc_v;
    logic signed [INTEG_SUM_W-1:0]  integ_sum;
    logic signed [INTEG_W-1:0]      integ_next;
    logic signed [DERR_W-1:0]       derr;
    logic signed [ACC_W-1:0]        acc_neg, mag_src;
    logic                           is_cool, is_heat;
    logic [MAG_W-1:0]               mag_cap;
    logic [DUTY_W-1:0]              chan_min, chan_diff, chan_duty;
    logic [SUM_W-1:0]               duty_sum;
    logic [STEP_W-1:0]              next_fan, next_heat;
    logic [PCT_W-1:0]               fan_tgt;
    logic [DUTY_W-1:0]              pwm_raw, pwm;
    logic [V_W:0]                   trial;
    logic                           take_bit;
    logic                           active;
    logic signed [MUL_W-1:0]        mul_a, mul_b;
    logic signed [PROD_W-1:0]       prod;

    phc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= KP_RESET;
            r_ki    <= KI_RESET;
            r_kd    <= KD_RESET;
            r_min1  <= FAN1_RESET;
            r_min2  <= FAN2_RESET;
            r_full  <= FULL_RESET;
            r_tlow  <= TLOW_RESET;
            r_thigh <= THIGH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:  r_kp    <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_ki    <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN: r_kd    <= i_cfg_data[GAIN_W-1:0];
                CFG_FAN1_MIN:   r_min1  <= i_cfg_data[DUTY_W-1:0];
                CFG_FAN2_MIN:   r_min2  <= i_cfg_data[DUTY_W-1:0];
                CFG_FULL_DUTY:  r_full  <= i_cfg_data[DUTY_W-1:0];
                CFG_TEMP_LOW:   r_tlow  <= $signed(i_cfg_data[TEMP_W-1:0]);
                CFG_TEMP_HIGH:  r_thigh <= $signed(i_cfg_data[TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    // Error, saturated to the error width
    always_comb begin
        sp_scaled = ERRF_W'(r_setpoint) << TEMP_FRAC_BITS;
        err_full  = $signed(sp_scaled) - ERRF_W'(r_temp);
        if (err_full > ERR_MAXV) begin
            err_sat = ERR_W'(ERR_MAXV);
        end else if (err_full < ERR_MINV) begin
            err_sat = ERR_W'(ERR_MINV);
        end else begin
            err_sat = ERR_W'(err_full);
        end
    end

    // Integrator step: round(e/10) with halves up, as a floor divide of (e+5)/10
    always_comb begin
        inc_x = (MUL_W'(r_err) <<< GAIN_ALIGN_SHIFT) + MUL_W'(INC_BIAS);
        inc_y = inc_x >>> TEMP_FRAC_BITS;
        inc_u = inc_y + MUL_W'(DIV10_OFS);
        inc_v = $signed(INC_W'(prod[DIV10_SHIFT +: DIV10_Q_W])) - INC_W'(DIV10_OFS_Q);
        integ_sum = INTEG_SUM_W'(r_integ) + INTEG_SUM_W'(inc_v);
        if (integ_sum > INTEG_LIMIT) begin
            integ_next = INTEG_W'(INTEG_LIMIT);
        end else if (integ_sum < -INTEG_LIMIT) begin
            integ_next = INTEG_W'(-INTEG_LIMIT);
        end else begin
            integ_next = INTEG_W'(integ_sum);
        end
        derr = DERR_W'(r_err) - DERR_W'(r_last);
    end

    // Deadband and magnitude clamp
    always_comb begin
        acc_neg = -r_acc;
        is_cool = (r_acc < -DB_LIM);
        is_heat = (r_acc > DB_LIM);
        mag_src = is_cool ? acc_neg : r_acc;
        mag_cap = (mag_src > FULL_MAG) ? MAG_W'(FULL_MAG) : MAG_W'(mag_src);
    end

    // Per-channel duty: min + floor(p * (full - min) / 100)
    always_comb begin
        case (r_chan)
            CH_FAN1: chan_min = r_min1;
            CH_FAN2: chan_min = r_min2;
            default: chan_min = '0;
        endcase
        chan_diff = r_full - chan_min;
        duty_sum  = {r_part, DUTY_W'(0)} + SUM_W'(prod[2*DUTY_W-1:0]);
        if (r_mag[MAG_W-1:SCALE_BITS] == '0) begin
            chan_duty = '0;
        end else if (chan_min >= r_full) begin
            chan_duty = r_full;
        end else begin
            chan_duty = chan_min + prod[DIV100_SHIFT +: DUTY_W];
        end
    end

    // Manual levels and heater percent divider step
    always_comb begin
        next_fan  = r_fan_step + 1'b1;
        next_heat = r_heat_step + 1'b1;
        fan_tgt   = fan_target(next_fan);
        case (next_heat)
            2'd1:    pwm_raw = HEAT_L1;
            2'd2:    pwm_raw = HEAT_L2;
            2'd3:    pwm_raw = r_full;
            default: pwm_raw = '0;
        endcase
        pwm      = (pwm_raw > r_full) ? r_full : pwm_raw;
        trial    = (V_W + 1)'(r_rem) - (V_W + 1)'(r_dsr);
        take_bit = !trial[V_W];
        active   = (r_mode == MODE_PID) || (r_mode == MODE_MAN);
    end

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_INC: begin
                mul_a = inc_u;
                mul_b = MUL_W'(DIV10_K);
            end
            S_INTEG: begin
                mul_a = MUL_W'(r_kp);
                mul_b = MUL_W'(r_err);
            end
            S_PTERM: begin
                mul_a = MUL_W'(r_ki);
                mul_b = MUL_W'(r_integ);
            end
            S_ITERM: begin
                mul_a = MUL_W'(r_kd);
                mul_b = MUL_W'(derr);
            end
            S_CHI: begin
                mul_a = MUL_W'(r_mag[MAG_W-1:DUTY_W]);
                mul_b = MUL_W'(chan_diff);
            end
            S_CLO: begin
                mul_a = MUL_W'(r_mag[DUTY_W-1:0]);
                mul_b = MUL_W'(chan_diff);
            end
            S_CDIV: begin
                mul_a = MUL_W'(r_v);
                mul_b = MUL_W'(DIV100_K);
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_setpoint  <= SP_RESET;
            r_integ     <= '0;
            r_last      <= '0;
            r_fan_step  <= '0;
            r_heat_step <= '0;
            r_duty      <= '{default: '0};
            r_power     <= '{default: '0};
            r_out_valid <= 1'b0;
            r_chan      <= CH_FAN1;
            r_cnt       <= '0;
        end else begin
            // S_DONE owns the valid flag while it publishes
            if (o_res.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_func  <= i_cmd.func;
                        r_temp  <= i_cmd.temperature;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_func)
                        FUNC_TICK: begin
                            r_state <= (r_mode == MODE_PID) ? S_INC : S_DONE;
                            if (r_mode == MODE_PID) begin
                                r_err <= err_sat;
                            end
                        end
                        FUNC_SAMPLE: begin
                            r_state <= S_DONE;
                            if (r_mode != MODE_SET && (r_temp < r_tlow || r_temp > r_thigh)) begin
                                r_mode <= MODE_ERR;
                            end
                        end
                        FUNC_MENU: begin
                            r_state <= S_DONE;
                            r_mode  <= (r_mode == MODE_IDLE) ? MODE_SET : MODE_IDLE;
                        end
                        FUNC_UP: begin
                            r_state <= (r_mode == MODE_MAN) ? S_CHI : S_DONE;
                            case (r_mode)
                                MODE_IDLE: begin
                                    r_mode  <= MODE_PID;
                                    r_integ <= '0;
                                end
                                MODE_SET: begin
                                    if (r_setpoint < SP_MAX) begin
                                        r_setpoint <= r_setpoint + 1'b1;
                                    end
                                end
                                MODE_MAN: begin
                                    r_fan_step  <= next_fan;
                                    r_heat_step <= '0;
                                    r_duty[CH_HEAT] <= '0;
                                    r_power[0]  <= fan_tgt;
                                    r_power[1]  <= '0;
                                    r_mag       <= MAG_W'(fan_tgt) << SCALE_BITS;
                                    r_chan      <= CH_FAN1;
                                end
                                default: ;
                            endcase
                        end
                        FUNC_DOWN: begin
                            r_state <= (r_mode == MODE_MAN && r_full != '0) ? S_HDIV : S_DONE;
                            case (r_mode)
                                MODE_IDLE: begin
                                    r_mode      <= MODE_MAN;
                                    r_fan_step  <= '0;
                                    r_heat_step <= '0;
                                end
                                MODE_SET: begin
                                    if (r_setpoint > SP_MIN) begin
                                        r_setpoint <= r_setpoint - 1'b1;
                                    end
                                end
                                MODE_MAN: begin
                                    r_heat_step <= next_heat;
                                    r_fan_step  <= '0;
                                    r_duty[CH_FAN1] <= '0;
                                    r_duty[CH_FAN2] <= '0;
                                    r_duty[CH_HEAT] <= pwm;
                                    r_power[0]  <= '0;
                                    r_power[1]  <= '0;
                                    r_rem       <= V_W'(pwm) * V_W'(PCT_FULL);
                                    r_dsr       <= DSR_W'(r_full) << (PCT_W - 1);
                                    r_q         <= '0;
                                    r_cnt       <= 3'(PCT_W - 1);
                                end
                                default: ;
                            endcase
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                // PID terms through the shared multiplier
                S_INC: begin
                    r_state <= S_INTEG;
                end
                S_INTEG: begin
                    r_integ <= integ_next;
                    r_state <= S_PTERM;
                end
                S_PTERM: begin
                    r_acc   <= ACC_W'(prod) <<< GAIN_ALIGN_SHIFT;
                    r_state <= S_ITERM;
                end
                S_ITERM: begin
                    r_acc   <= r_acc + (ACC_W'(prod) <<< TEMP_FRAC_BITS);
                    r_state <= S_DTERM;
                end
                S_DTERM: begin
                    r_acc   <= r_acc + (ACC_W'(prod) <<< GAIN_ALIGN_SHIFT);
                    r_last  <= r_err;
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    r_duty     <= '{default: '0};
                    r_power[0] <= is_cool ? mag_cap[SCALE_BITS +: PCT_W] : '0;
                    r_power[1] <= is_heat ? mag_cap[SCALE_BITS +: PCT_W] : '0;
                    r_mag      <= mag_cap;
                    if (is_cool) begin
                        r_chan     <= CH_FAN1;
                        r_state    <= S_CHI;
                    end else if (is_heat) begin
                        r_chan     <= CH_HEAT;
                        r_state    <= S_CHI;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // Duty for one channel, split product then divide by 100
                S_CHI: begin
                    r_state <= S_CLO;
                end
                S_CLO: begin
                    r_part  <= prod[MAG_W-1:0];
                    r_state <= S_CSUM;
                end
                S_CSUM: begin
                    r_v     <= duty_sum[SCALE_BITS +: V_W];
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    r_state <= S_CFIN;
                end
                S_CFIN: begin
                    r_duty[r_chan] <= chan_duty;
                    if (r_chan == CH_FAN1) begin
                        r_chan  <= CH_FAN2;
                        r_state <= S_CHI;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // Heater percent, one quotient bit per cycle
                S_HDIV: begin
                    if (take_bit) begin
                        r_rem <= trial[V_W-1:0];
                    end
                    r_dsr <= r_dsr >> 1;
                    r_q   <= {r_q[PCT_W-2:0], take_bit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_power[1] <= {r_q[PCT_W-2:0], take_bit};
                        r_state    <= S_DONE;
                    end
                end
                // Publish the status transaction
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_res.mode             <= r_mode;
                        r_res.setpoint_deg     <= r_setpoint;
                        r_res.first_fan_duty   <= active ? r_duty[CH_FAN1] : '0;
                        r_res.second_fan_duty  <= active ? r_duty[CH_FAN2] : '0;
                        r_res.heater_duty      <= active ? r_duty[CH_HEAT] : '0;
                        r_res.fan_percent      <= active ? r_power[0] : '0;
                        r_res.heater_percent   <= active ? r_power[1] : '0;
                        r_res.manual_fan_step  <= r_fan_step;
                        r_res.manual_heat_step <= r_heat_step;
                        if (!active) begin
                            r_duty  <= '{default: '0};
                            r_power <= '{default: '0};
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready            = (r_state == S_IDLE);
    assign o_res.valid            = r_out_valid;
    assign o_res.mode             = r_res.mode;
    assign o_res.setpoint_deg     = r_res.setpoint_deg;
    assign o_res.first_fan_duty   = r_res.first_fan_duty;
    assign o_res.second_fan_duty  = r_res.second_fan_duty;
    assign o_res.heater_duty      = r_res.heater_duty;
    assign o_res.fan_percent      = r_res.fan_percent;
    assign o_res.heater_percent   = r_res.heater_percent;
    assign o_res.manual_fan_step  = r_res.manual_fan_step;
    assign o_res.manual_heat_step = r_res.manual_heat_step;

endmodule

// ===== test/phc_checker.sv =====
`timescale 1ns / 1ps

// Watches the event and status channels, runs a cycle-free model of the
// controller on every accepted event and checks each status transaction
// against the oldest outstanding prediction.
module phc_checker import phc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    phc_in_if                     cmd_mon,
    phc_out_if                    res_mon,
    output int                    o_err_count,
    output int                    o_pending,
    output int                    o_checked,
    output t_mode                 o_mode,
    output logic [SP_W-1:0]       o_setpoint
);

    // Register copies
    logic [GAIN_W-1:0] kp_gain, ki_gain, kd_gain;
    logic [DUTY_W-1:0] fan1_min, fan2_min, full_duty;
    longint            temp_lo, temp_hi;

    // Controller state
    t_mode             ctl_mode;
    logic [SP_W-1:0]   sp_deg;
    longint            integ_acc, prev_err;
    logic [STEP_W-1:0] fan_lvl, heat_lvl;
    logic [DUTY_W-1:0] duty_fan1, duty_fan2, duty_htr;
    logic [PCT_W-1:0]  pct_fan, pct_heat;

    t_result status_q[$];
    int      mismatches = 0;
    int      checked    = 0;

    function automatic longint div_floor(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    // Fan compare value for a fraction num/den of full power
    function automatic logic [DUTY_W-1:0] fan_compare(input longint num, input longint den,
                                                      input longint lo_duty);
        longint full_v;
        full_v = full_duty;
        if (num * 100 < den) return '0;
        if (lo_duty >= full_v) return full_duty;
        return DUTY_W'(lo_duty + (num * (full_v - lo_duty)) / den);
    endfunction

    task automatic clear_drive();
        duty_fan1 = '0;
        duty_fan2 = '0;
        duty_htr  = '0;
        pct_fan   = '0;
        pct_heat  = '0;
    endtask

    // One PID pass; output scaled in 2^-SCALE_BITS percent
    task automatic pid_update(input longint temp);
        longint unit_v, hundred, fscale, align, sp_v, full_v;
        longint kp_v, ki_v, kd_v;
        longint err, inc, diff, drive, mag;
        unit_v  = PCT_UNIT;
        hundred = PCT_FULL * unit_v;
        fscale  = longint'(1) <<< TEMP_FRAC_BITS;
        align   = 256;
        sp_v    = sp_deg;
        full_v  = full_duty;
        kp_v    = kp_gain;
        ki_v    = ki_gain;
        kd_v    = kd_gain;

        err = sp_v * fscale - temp;
        if (err > ERR_MAXV) err = ERR_MAXV;
        if (err < ERR_MINV) err = ERR_MINV;

        // integral gets a tenth of the error, halves rounded up
        inc = div_floor(2 * err * align + 10 * fscale, 20 * fscale);
        integ_acc = integ_acc + inc;
        if (integ_acc > INTEG_LIMIT) integ_acc = INTEG_LIMIT;
        if (integ_acc < -INTEG_LIMIT) integ_acc = -INTEG_LIMIT;

        diff  = err - prev_err;
        drive = kp_v * err * align + ki_v * integ_acc * fscale + kd_v * diff * align;

        clear_drive();
        if (drive < -DEADBAND_PCT * unit_v) begin
            mag = -drive;
            if (mag > hundred) mag = hundred;
            duty_fan1 = fan_compare(mag, hundred, fan1_min);
            duty_fan2 = fan_compare(mag, hundred, fan2_min);
            pct_fan   = PCT_W'(mag / unit_v);
        end else if (drive > DEADBAND_PCT * unit_v) begin
            mag = drive;
            if (mag > hundred) mag = hundred;
            duty_htr  = DUTY_W'((mag * full_v) / hundred);
            pct_heat  = PCT_W'(mag / unit_v);
        end
        prev_err = err;
    endtask

    // Apply one event to the model state
    task automatic step_event(input logic [FUNC_W-1:0] func, input longint temp);
        longint tgt, pwm, full_v;
        full_v = full_duty;
        case (func)
            FUNC_TICK: begin
                if (ctl_mode == MODE_PID) pid_update(temp);
            end
            FUNC_SAMPLE: begin
                if (ctl_mode != MODE_SET && (temp < temp_lo || temp > temp_hi))
                    ctl_mode = MODE_ERR;
            end
            FUNC_MENU: begin
                ctl_mode = (ctl_mode == MODE_IDLE) ? MODE_SET : MODE_IDLE;
            end
            FUNC_UP: begin
                case (ctl_mode)
                    MODE_IDLE: begin
                        ctl_mode  = MODE_PID;
                        integ_acc = 0;
                    end
                    MODE_SET: begin
                        if (sp_deg < SP_MAX) sp_deg = sp_deg + 1'b1;
                    end
                    MODE_MAN: begin
                        // next fan level, heater off
                        fan_lvl  = fan_lvl + 1'b1;
                        heat_lvl = '0;
                        case (fan_lvl)
                            2'd1:    tgt = FAN_T1;
                            2'd2:    tgt = FAN_T2;
                            2'd3:    tgt = FAN_T3;
                            default: tgt = 0;
                        endcase
                        duty_fan1 = fan_compare(tgt, 100, fan1_min);
                        duty_fan2 = fan_compare(tgt, 100, fan2_min);
                        duty_htr  = '0;
                        pct_fan   = PCT_W'(tgt);
                        pct_heat  = '0;
                    end
                    default: ;
                endcase
            end
            FUNC_DOWN: begin
                case (ctl_mode)
                    MODE_IDLE: begin
                        ctl_mode = MODE_MAN;
                        fan_lvl  = '0;
                        heat_lvl = '0;
                    end
                    MODE_SET: begin
                        if (sp_deg > SP_MIN) sp_deg = sp_deg - 1'b1;
                    end
                    MODE_MAN: begin
                        // next heater level, fans off
                        heat_lvl = heat_lvl + 1'b1;
                        fan_lvl  = '0;
                        case (heat_lvl)
                            2'd1:    pwm = HEAT_L1;
                            2'd2:    pwm = HEAT_L2;
                            2'd3:    pwm = full_v;
                            default: pwm = 0;
                        endcase
                        if (pwm > full_v) pwm = full_v;
                        duty_fan1 = '0;
                        duty_fan2 = '0;
                        duty_htr  = DUTY_W'(pwm);
                        pct_fan   = '0;
                        pct_heat  = (full_v != 0) ? PCT_W'((pwm * 100) / full_v) : '0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (ctl_mode != MODE_PID && ctl_mode != MODE_MAN) clear_drive();
    endtask

    function automatic bit field_ok(input string label, input logic [31:0] want_v,
                                    input logic [31:0] got_v, input bit show, input int idx);
        if (want_v !== got_v && show)
            $display("status %0d %s: expected %0d, got %0d", idx, label, want_v, got_v);
        return want_v === got_v;
    endfunction

    // Model update and comparison
    always @(posedge i_clk) begin
        t_result want;
        bit      ok;
        bit      show;
        if (!i_rst_n) begin
            kp_gain   = KP_RESET;
            ki_gain   = KI_RESET;
            kd_gain   = KD_RESET;
            fan1_min  = FAN1_RESET;
            fan2_min  = FAN2_RESET;
            full_duty = FULL_RESET;
            temp_lo   = TLOW_RESET;
            temp_hi   = THIGH_RESET;
            ctl_mode  = MODE_IDLE;
            sp_deg    = SP_RESET;
            integ_acc = 0;
            prev_err  = 0;
            fan_lvl   = '0;
            heat_lvl  = '0;
            clear_drive();
            status_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PROP_GAIN:  kp_gain   = i_cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN: ki_gain   = i_cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN: kd_gain   = i_cfg_data[GAIN_W-1:0];
                    CFG_FAN1_MIN:   fan1_min  = i_cfg_data[DUTY_W-1:0];
                    CFG_FAN2_MIN:   fan2_min  = i_cfg_data[DUTY_W-1:0];
                    CFG_FULL_DUTY:  full_duty = i_cfg_data[DUTY_W-1:0];
                    CFG_TEMP_LOW:   temp_lo   = $signed(i_cfg_data);
                    CFG_TEMP_HIGH:  temp_hi   = $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // status transaction against oldest prediction
            if (res_mon.valid && res_mon.ready) begin
                if (status_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("status transaction with nothing outstanding at %0t", $time);
                    mismatches++;
                end else begin
                    want = status_q.pop_front();
                    show = (mismatches < 10);
                    ok = 1'b1;
                    ok &= field_ok("mode", want.mode, res_mon.mode, show, checked);
                    ok &= field_ok("setpoint_deg", want.setpoint_deg, res_mon.setpoint_deg,
                                   show, checked);
                    ok &= field_ok("first_fan_duty", want.first_fan_duty,
                                   res_mon.first_fan_duty, show, checked);
                    ok &= field_ok("second_fan_duty", want.second_fan_duty,
                                   res_mon.second_fan_duty, show, checked);
                    ok &= field_ok("heater_duty", want.heater_duty, res_mon.heater_duty,
                                   show, checked);
                    ok &= field_ok("fan_percent", want.fan_percent, res_mon.fan_percent,
                                   show, checked);
                    ok &= field_ok("heater_percent", want.heater_percent,
                                   res_mon.heater_percent, show, checked);
                    ok &= field_ok("manual_fan_step", want.manual_fan_step,
                                   res_mon.manual_fan_step, show, checked);
                    ok &= field_ok("manual_heat_step", want.manual_heat_step,
                                   res_mon.manual_heat_step, show, checked);
                    if (!ok) mismatches++;
                    checked++;
                end
            end

            // event transaction: predict its status
            if (cmd_mon.valid && cmd_mon.ready) begin
                step_event(cmd_mon.func, cmd_mon.temperature);
                want.mode             = ctl_mode;
                want.setpoint_deg     = sp_deg;
                want.first_fan_duty   = duty_fan1;
                want.second_fan_duty  = duty_fan2;
                want.heater_duty      = duty_htr;
                want.fan_percent      = pct_fan;
                want.heater_percent   = pct_heat;
                want.manual_fan_step  = fan_lvl;
                want.manual_heat_step = heat_lvl;
                status_q.push_back(want);
            end
        end

        o_pending   <= status_q.size();
        o_err_count <= mismatches;
        o_checked   <= checked;
        o_mode      <= ctl_mode;
        o_setpoint  <= sp_deg;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import phc_pkg::*;

    localparam int ITEM_TARGET    = 1350;
    localparam int PHASES         = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int TEMP_MIN       = -11520;
    localparam int TEMP_MAX       = 33280;

    // codes the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    phc_in_if  cmd_if ();
    phc_out_if res_if ();

    int              err_count;
    int              pending;
    int              checked;
    t_mode           mode_now;
    logic [SP_W-1:0] sp_now;

    bit fast_mode     = 1'b0;
    int items_counted = 0;
    int items_sent    = 0;
    int cfg_sets      = 0;
    int idle_cycles   = 0;
    int temp_lo_now;
    int temp_hi_now;

    always #5 i_clk = ~i_clk;

    pid_heat_cool_mode_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd_if),
        .o_res       (res_if)
    );

    phc_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .cmd_mon     (cmd_if),
        .res_mon     (res_if),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_mode      (mode_now),
        .o_setpoint  (sp_now)
    );

    // Status back-pressure: mostly ready, short stalls, a few long ones
    initial begin
        int  hold;
        int  r;
        bit  level;
        hold  = 0;
        level = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold <= 0) begin
                r = $urandom_range(0, 99);
                if (fast_mode || r < 55) begin
                    level = 1'b1;
                    hold  = fast_mode ? 1 : $urandom_range(1, 12);
                end else if (r < 90) begin
                    level = 1'b0;
                    hold  = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    hold  = $urandom_range(10, 40);
                end
            end
            res_if.ready <= level;
            hold--;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (fast_mode || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int rand_temp();
        return int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
    endfunction

    // Temperature around the setpoint: deadband, moderate or anywhere
    function automatic int near_setpoint();
        int base, r, t;
        base = int'(sp_now) * 256;
        r = $urandom_range(0, 99);
        if (r < 40) t = base + int'($urandom_range(0, 1024)) - 512;
        else if (r < 75) t = base + int'($urandom_range(0, 6000)) - 3000;
        else t = rand_temp();
        if (t < TEMP_MIN) t = TEMP_MIN;
        if (t > TEMP_MAX) t = TEMP_MAX;
        return t;
    endfunction

    function automatic int in_limits();
        if (temp_lo_now > temp_hi_now) return rand_temp();
        return int'($urandom_range(0, temp_hi_now - temp_lo_now)) + temp_lo_now;
    endfunction

    task automatic send_evt(input logic [FUNC_W-1:0] func, input int temp, input bit counts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.func        <= func;
        cmd_if.temperature <= TEMP_W'(temp);
        do @(posedge i_clk); while (!cmd_if.ready);
        items_sent++;
        if (counts) items_counted++;
    endtask

    // Hold off events until every predicted status has arrived
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        @(posedge i_clk);
    endtask

    task automatic program_regs(input int kp, input int ki, input int kd, input int f1,
                                input int f2, input int full, input int tlo, input int thi);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_FAN1_MIN, f1);
        write_reg(CFG_FAN2_MIN, f2);
        write_reg(CFG_FULL_DUTY, full);
        write_reg(CFG_TEMP_LOW, tlo);
        write_reg(CFG_TEMP_HIGH, thi);
        i_cfg_wr_en <= 1'b0;
        temp_lo_now = tlo;
        temp_hi_now = thi;
        cfg_sets++;
    endtask

    // One session from idle: auto, setpoint trim, manual or noise
    task automatic run_scenario();
        int kind, n, r, bias;
        logic [FUNC_W-1:0] f;
        wait_drained();
        fast_mode = ($urandom_range(0, 99) < 15);
        if (mode_now != MODE_IDLE) send_evt(FUNC_MENU, rand_temp(), 1'b0);
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            send_evt(FUNC_UP, rand_temp(), 1'b1);
            n = $urandom_range(5, 40);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 75) send_evt(FUNC_TICK, near_setpoint(), 1'b1);
                else if (r < 88) send_evt(FUNC_SAMPLE, in_limits(), 1'b1);
                else if (r < 92) send_evt(FUNC_SAMPLE, rand_temp(), 1'b1);
                else if (r < 96) send_evt(r[0] ? FUNC_UP : FUNC_DOWN, rand_temp(), 1'b0);
                else send_evt(FUNC_W'($urandom_range(0, 7)), rand_temp(), 1'b0);
            end
        end else if (kind < 60) begin
            send_evt(FUNC_MENU, rand_temp(), 1'b1);
            bias = $urandom_range(0, 2);
            n = $urandom_range(1, 45);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r >= 90) begin
                    send_evt(r[0] ? FUNC_SAMPLE : FUNC_TICK, rand_temp(), 1'b0);
                end else begin
                    // up-heavy, down-heavy or mixed runs to reach both setpoint ends
                    r = $urandom_range(0, 99);
                    if ((bias == 0 && r < 80) || (bias == 1 && r < 20) || (bias == 2 && r < 50))
                        send_evt(FUNC_UP, rand_temp(), 1'b1);
                    else
                        send_evt(FUNC_DOWN, rand_temp(), 1'b1);
                end
            end
            send_evt(FUNC_MENU, rand_temp(), 1'b1);
        end else if (kind < 85) begin
            send_evt(FUNC_DOWN, rand_temp(), 1'b1);
            n = $urandom_range(1, 20);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 40) send_evt(FUNC_UP, rand_temp(), 1'b1);
                else if (r < 80) send_evt(FUNC_DOWN, rand_temp(), 1'b1);
                else if (r < 90) send_evt(FUNC_TICK, rand_temp(), 1'b0);
                else send_evt(FUNC_SAMPLE, in_limits(), 1'b0);
            end
        end else begin
            n = $urandom_range(3, 15);
            repeat (n) begin
                f = FUNC_W'($urandom_range(0, 7));
                send_evt(f, rand_temp(), (f != FUNC_TICK && f <= FUNC_DOWN));
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        int phase;
        int full_r;
        int ta, tb;
        cmd_if.valid       = 1'b0;
        cmd_if.func        = FUNC_TICK;
        cmd_if.temperature = '0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_index        = CFG_PROP_GAIN;
        i_cfg_data         = '0;
        temp_lo_now        = TLOW_RESET;
        temp_hi_now        = THIGH_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass on reset register values
        send_evt(FUNC_TICK, 0, 1'b0);          // tick while idle
        send_evt(FUNC_SAMPLE, 2560, 1'b0);     // in-range sample
        send_evt(FUNC_UP, 0, 1'b0);            // enter auto
        send_evt(FUNC_TICK, 6400, 1'b0);       // zero error, deadband
        send_evt(FUNC_TICK, TEMP_MIN, 1'b0);   // full heating
        send_evt(FUNC_TICK, TEMP_MAX, 1'b0);   // full cooling
        send_evt(FUNC_TICK, 6350, 1'b0);
        send_evt(FUNC_UP, 0, 1'b0);            // ignored in auto
        send_evt(FUNC_DOWN, 0, 1'b0);
        send_evt(FUNC_SPARE_LO, TEMP_MAX, 1'b0);
        send_evt(FUNC_SPARE_HI, TEMP_MIN, 1'b0);
        send_evt(FUNC_SAMPLE, TEMP_MAX, 1'b0); // over limit, to error
        send_evt(FUNC_TICK, 0, 1'b0);
        send_evt(FUNC_UP, 0, 1'b0);
        send_evt(FUNC_DOWN, 0, 1'b0);
        send_evt(FUNC_SAMPLE, TEMP_MIN, 1'b0);
        send_evt(FUNC_MENU, 0, 1'b0);          // error back to idle
        send_evt(FUNC_MENU, 0, 1'b0);          // setting
        send_evt(FUNC_UP, 0, 1'b0);
        send_evt(FUNC_DOWN, 0, 1'b0);
        send_evt(FUNC_SAMPLE, TEMP_MIN, 1'b0); // no error while setting
        send_evt(FUNC_MENU, 0, 1'b0);
        send_evt(FUNC_DOWN, 0, 1'b0);          // manual
        send_evt(FUNC_UP, 0, 1'b0);            // fan level 1
        send_evt(FUNC_DOWN, 0, 1'b0);          // heater level 1, fan cleared

        // Random sessions under several register sets
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: ;
                1: program_regs(65535, 65535, 65535, 0, 0, 16383, TEMP_MIN, TEMP_MAX);
                2: program_regs(0, 0, 0, 16383, 0, 1, TEMP_MAX, TEMP_MIN);
                4: program_regs(3000, 9000, 20000, 3000, 2500, 2000, -2560, 10240);
                default: begin
                    full_r = $urandom_range(1, 16383);
                    ta = rand_temp();
                    tb = rand_temp();
                    program_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535),
                                 ($urandom_range(0, 9) < 7) ? $urandom_range(0, full_r)
                                                            : $urandom_range(0, 16383),
                                 ($urandom_range(0, 9) < 7) ? $urandom_range(0, full_r)
                                                            : $urandom_range(0, 16383),
                                 full_r, (ta < tb) ? ta : tb, (ta < tb) ? tb : ta);
                end
            endcase
            while (items_counted < (phase + 1) * ITEM_TARGET / PHASES) run_scenario();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d events (%0d in mode sessions), %0d status checks",
                 items_sent, items_counted, checked);
        $display("register sets applied after reset: %0d, full-scale and minimum included",
                 cfg_sets);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/phc_pkg.sv
rtl/core/phc_if.sv
rtl/core/phc_mul.sv
rtl/core/pid_heat_cool_mode_controller.sv
test/phc_checker.sv
test/testbench.sv
